FILE: rtl/core/ascnt_pkg.sv
// ----------------------------------------------------------------------------
// Accelerometer step counter package
// Shared widths, register reset values, register indexes and the
// configuration bundle used by the step counter modules.
// ----------------------------------------------------------------------------
package ascnt_pkg;

    localparam int ACC_W   = 16;   // one acceleration axis, signed Q4.12
    localparam int TICK_W  = 32;
    localparam int COUNT_W = 32;
    localparam int MAG_W   = 16;   // magnitude, unsigned Q4.12
    localparam int SUM_W   = 32;   // sum of three squares
    localparam int FILT_W  = 24;   // filter state, Q4.20
    localparam int CFG_W   = 16;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Every serial unit handles one bit of a 16-bit operand or result per cycle.
    localparam int SERIAL_STEPS = 16;
    localparam int CNT_W        = $clog2(SERIAL_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SERIAL_STEPS - 1);

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd4506;
    localparam logic [CFG_W-1:0] INTERVAL_RST  = 16'd200;
    localparam logic [CFG_W-1:0] GAIN_RST      = 16'd6554;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_GAIN      = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] detect_level;
        logic [CFG_W-1:0] min_step_interval;
        logic [CFG_W-1:0] filter_gain;
    } cfg_t;

endpackage

FILE: rtl/core/ascnt_sample_if.sv
// ----------------------------------------------------------------------------
// Accelerometer sample channel
// Valid/ready channel carrying one three-axis sample and its tick.
// ----------------------------------------------------------------------------
interface ascnt_sample_if;

    logic                              valid;
    logic                              ready;
    logic signed [ascnt_pkg::ACC_W-1:0] accel_x;
    logic signed [ascnt_pkg::ACC_W-1:0] accel_y;
    logic signed [ascnt_pkg::ACC_W-1:0] accel_z;
    logic [ascnt_pkg::TICK_W-1:0]       tick_now;

    modport source (
        output valid,
        output accel_x,
        output accel_y,
        output accel_z,
        output tick_now,
        input  ready
    );

    modport sink (
        input  valid,
        input  accel_x,
        input  accel_y,
        input  accel_z,
        input  tick_now,
        output ready
    );

endinterface

FILE: rtl/core/ascnt_result_if.sv
// ----------------------------------------------------------------------------
// Step counter result channel
// Valid/ready channel carrying the step total, step flag and filtered
// magnitude produced for each sample.
// ----------------------------------------------------------------------------
interface ascnt_result_if;

    logic                           valid;
    logic                           ready;
    logic [ascnt_pkg::COUNT_W-1:0]  step_total;
    logic                           step_seen;
    logic [ascnt_pkg::MAG_W-1:0]    filtered_mag;

    modport source (
        output valid,
        output step_total,
        output step_seen,
        output filtered_mag,
        input  ready
    );

    modport sink (
        input  valid,
        input  step_total,
        input  step_seen,
        input  filtered_mag,
        output ready
    );

endinterface

FILE: rtl/core/ascnt_regs.sv
// ----------------------------------------------------------------------------
// Step counter configuration registers
// APB-style register file holding threshold, interval and filter gain.
// ----------------------------------------------------------------------------
module ascnt_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ascnt_pkg::PADDR_W-1:0]   paddr,
    input  logic [ascnt_pkg::PDATA_W-1:0]   pwdata,
    output logic [ascnt_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready,
    output ascnt_pkg::cfg_t                 cfg
);

    ascnt_pkg::cfg_t cfg_reg;
    ascnt_pkg::cfg_t cfg_next;
    logic [1:0]      index;
    logic            wr_en;

    assign index  = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                ascnt_pkg::REG_THRESHOLD:
                    cfg_next.detect_level = pwdata[ascnt_pkg::CFG_W-1:0];
                ascnt_pkg::REG_INTERVAL:
                    cfg_next.min_step_interval = pwdata[ascnt_pkg::CFG_W-1:0];
                ascnt_pkg::REG_GAIN:
                    cfg_next.filter_gain = pwdata[ascnt_pkg::CFG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            ascnt_pkg::REG_THRESHOLD:
                prdata = ascnt_pkg::PDATA_W'(cfg_reg.detect_level);
            ascnt_pkg::REG_INTERVAL:
                prdata = ascnt_pkg::PDATA_W'(cfg_reg.min_step_interval);
            ascnt_pkg::REG_GAIN:
                prdata = ascnt_pkg::PDATA_W'(cfg_reg.filter_gain);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_level      <= ascnt_pkg::THRESHOLD_RST;
            cfg_reg.min_step_interval <= ascnt_pkg::INTERVAL_RST;
            cfg_reg.filter_gain       <= ascnt_pkg::GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/ascnt_sqsum.sv
// ----------------------------------------------------------------------------
// Step counter sum of squares
// Three bit-serial squarers, one per axis, followed by a final add.
// ----------------------------------------------------------------------------
module ascnt_sqsum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ascnt_pkg::ACC_W-1:0]  accel_x,
    input  logic signed [ascnt_pkg::ACC_W-1:0]  accel_y,
    input  logic signed [ascnt_pkg::ACC_W-1:0]  accel_z,
    output logic                                done,
    output logic [ascnt_pkg::SUM_W-1:0]         sum
);

    localparam int LANES = 3;
    localparam int W     = ascnt_pkg::ACC_W;

    function automatic logic [W-1:0] abs_val(input logic signed [W-1:0] a);
        // The most negative code maps to its unsigned magnitude.
        return a[W-1] ? W'(-a) : W'(a);
    endfunction

    logic                          busy_reg, busy_next;
    logic                          add_reg, add_next;
    logic                          done_reg, done_next;
    logic [ascnt_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                  mcand_reg [LANES];
    logic [W-1:0]                  mcand_next [LANES];
    logic [W-1:0]                  mplier_reg [LANES];
    logic [W-1:0]                  mplier_next [LANES];
    logic [2*W-1:0]                prod_reg [LANES];
    logic [2*W-1:0]                prod_next [LANES];
    logic [ascnt_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic signed [W-1:0]           axis [LANES];

    assign axis[0] = accel_x;
    assign axis[1] = accel_y;
    assign axis[2] = accel_z;
    assign done    = done_reg;
    assign sum     = sum_reg;

    always_comb
    begin
        logic [W:0] partial;
        partial   = '0;
        busy_next = busy_reg;
        add_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        for (int i = 0; i < LANES; i++)
        begin
            mcand_next[i]  = mcand_reg[i];
            mplier_next[i] = mplier_reg[i];
            prod_next[i]   = prod_reg[i];
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            for (int i = 0; i < LANES; i++)
            begin
                mcand_next[i]  = abs_val(axis[i]);
                mplier_next[i] = abs_val(axis[i]);
                prod_next[i]   = '0;
            end
        end
        else if (busy_reg)
        begin
            // Shift-right multiply: add the multiplicand into the upper half
            // when the current multiplier bit is set, then shift one place.
            for (int i = 0; i < LANES; i++)
            begin
                partial = {1'b0, prod_reg[i][2*W-1:W]}
                        + (mplier_reg[i][0] ? {1'b0, mcand_reg[i]} : '0);
                prod_next[i]   = {partial, prod_reg[i][W-1:1]};
                mplier_next[i] = mplier_reg[i] >> 1;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ascnt_pkg::CNT_LAST)
            begin
                busy_next = 1'b0;
                add_next  = 1'b1;
            end
        end
        if (add_reg)
        begin
            sum_next  = prod_reg[0] + prod_reg[1] + prod_reg[2];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            add_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            add_reg  <= add_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
    end

endmodule

FILE: rtl/core/ascnt_isqrt.sv
// ----------------------------------------------------------------------------
// Step counter square root
// Restoring integer square root, two radicand bits and one root bit a cycle.
// ----------------------------------------------------------------------------
module ascnt_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ascnt_pkg::SUM_W-1:0]   value,
    output logic                          done,
    output logic [ascnt_pkg::MAG_W-1:0]   root
);

    localparam int RW  = ascnt_pkg::MAG_W;
    localparam int RMW = RW + 1;    // remainder never exceeds twice the root
    localparam int TW  = RW + 3;    // shifted remainder and trial value

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ascnt_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ascnt_pkg::SUM_W-1:0]   val_reg, val_next;
    logic [RMW-1:0]                rem_reg, rem_next;
    logic [RW-1:0]                 root_reg, root_next;
    logic [TW-1:0]                 rem_sh;
    logic [TW-1:0]                 trial;
    logic [TW-1:0]                 diff;

    assign rem_sh = {rem_reg, val_reg[ascnt_pkg::SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign done   = done_reg;
    assign root   = root_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[ascnt_pkg::SUM_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = diff[RMW-1:0];
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[RMW-1:0];
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ascnt_pkg::CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

FILE: rtl/core/ascnt_lpf.sv
// ----------------------------------------------------------------------------
// Step counter low-pass filter
// Holds the Q4.20 filter state and moves it toward the new magnitude by
// gain/65536 of the difference, using a bit-serial signed multiply.
// ----------------------------------------------------------------------------
module ascnt_lpf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ascnt_pkg::MAG_W-1:0]   mag,
    input  logic [ascnt_pkg::CFG_W-1:0]   gain,
    output logic                          done,
    output logic [ascnt_pkg::FILT_W-1:0]  filt
);

    localparam int FW = ascnt_pkg::FILT_W;
    localparam int DW = FW + 1;     // signed difference of two Q4.20 values
    localparam int AW = FW + 2;     // accumulator plus one addend

    logic                          busy_reg, busy_next;
    logic                          fin_reg, fin_next;
    logic                          done_reg, done_next;
    logic [ascnt_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ascnt_pkg::CFG_W-1:0]   gain_reg, gain_next;
    logic signed [DW-1:0]          diff_reg, diff_next;
    logic signed [AW-1:0]          acc_reg, acc_next;
    logic [FW-1:0]                 filt_reg, filt_next;
    logic signed [AW-1:0]          addend;
    logic signed [AW-1:0]          acc_sum;

    assign addend  = gain_reg[0] ? $signed({diff_reg[DW-1], diff_reg}) : '0;
    assign acc_sum = acc_reg + addend;
    assign done    = done_reg;
    assign filt    = filt_reg;

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        gain_next = gain_reg;
        diff_next = diff_reg;
        acc_next  = acc_reg;
        filt_next = filt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            gain_next = gain;
            diff_next = $signed({1'b0, mag, 8'b0}) - $signed({1'b0, filt_reg});
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            // The arithmetic shift each step floors, so after all gain bits
            // the accumulator holds floor(gain * diff / 65536).
            acc_next  = acc_sum >>> 1;
            gain_next = gain_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == ascnt_pkg::CNT_LAST)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        if (fin_reg)
        begin
            filt_next = filt_reg + acc_reg[FW-1:0];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            filt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            filt_reg <= filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= gain_next;
        diff_reg <= diff_next;
        acc_reg  <= acc_next;
    end

endmodule

FILE: rtl/core/accel_step_counter_top.sv
// ----------------------------------------------------------------------------
// Accelerometer step counter
// Magnitude, low-pass filter and step detection for three-axis samples.
// ----------------------------------------------------------------------------
// Each accepted sample produces exactly one result, which is loaded into the
// output register once step detection is done; the next sample can be taken
// in the cycle after that, and no new sample is taken before then.
// The time to a result is set by three bit-serial units that run one after the other,
// each stepping through 16 bits: the three axis squarers with their final add,
// the square root and the filter multiply, followed by step detection, which
// moves to ST_FIN and then loads the result. The block handles one sample at a
// time and is ready for the next as soon as its result sits in the output
// register, even if that result has not been taken yet; a result still
// waiting there holds back the one behind it.
// Configuration registers (threshold at 0x0, minimum interval at 0x4, filter
// gain at 0x8) should be written only while no sample is in flight.
module accel_step_counter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    ascnt_sample_if.sink                    accel,
    ascnt_result_if.source                  report,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ascnt_pkg::PADDR_W-1:0]   paddr,
    input  logic [ascnt_pkg::PDATA_W-1:0]   pwdata,
    output logic [ascnt_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    ascnt_pkg::cfg_t                  cfg;
    logic [1:0]                       state_reg, state_next;
    logic [ascnt_pkg::TICK_W-1:0]     tick_reg, tick_next;
    logic [ascnt_pkg::TICK_W-1:0]     last_time_reg, last_time_next;
    logic [ascnt_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                             out_valid_reg, out_valid_next;
    logic [ascnt_pkg::COUNT_W-1:0]    total_reg, total_next;
    logic                             seen_reg, seen_next;
    logic [ascnt_pkg::MAG_W-1:0]      fmag_reg, fmag_next;

    logic                             accept;
    logic                             sq_done;
    logic [ascnt_pkg::SUM_W-1:0]      sq_sum;
    logic                             rt_done;
    logic [ascnt_pkg::MAG_W-1:0]      rt_root;
    logic                             lp_done;
    logic [ascnt_pkg::FILT_W-1:0]     lp_filt;
    logic [ascnt_pkg::TICK_W-1:0]     gap;
    logic                             over;
    logic                             hit;
    logic                             emit;

    ascnt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ascnt_sqsum u_sqsum (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .accel_x (accel.accel_x),
        .accel_y (accel.accel_y),
        .accel_z (accel.accel_z),
        .done    (sq_done),
        .sum     (sq_sum)
    );

    ascnt_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_done),
        .value (sq_sum),
        .done  (rt_done),
        .root  (rt_root)
    );

    ascnt_lpf u_lpf (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rt_done),
        .mag   (rt_root),
        .gain  (cfg.filter_gain),
        .done  (lp_done),
        .filt  (lp_filt)
    );

    assign accel.ready = (state_reg == ST_IDLE);
    assign accept      = accel.valid & accel.ready;

    assign report.valid        = out_valid_reg;
    assign report.step_total   = total_reg;
    assign report.step_seen    = seen_reg;
    assign report.filtered_mag = fmag_reg;

    // The threshold is compared at full filter precision, not on the output.
    assign over = lp_filt > {cfg.detect_level, 8'b0};
    assign gap  = tick_reg - last_time_reg;
    assign hit  = over && (gap > ascnt_pkg::TICK_W'(cfg.min_step_interval));
    assign emit = (state_reg == ST_FIN) && (!out_valid_reg || report.ready);

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        last_time_next = last_time_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        total_next     = total_reg;
        seen_next      = seen_reg;
        fmag_next      = fmag_reg;

        if (out_valid_reg && report.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tick_next  = accel.tick_now;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (lp_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (emit)
                begin
                    if (hit)
                    begin
                        count_next     = count_reg + 1'b1;
                        last_time_next = tick_reg;
                        total_next     = count_reg + 1'b1;
                    end
                    else
                    begin
                        total_next = count_reg;
                    end
                    seen_next      = hit;
                    fmag_next      = lp_filt[ascnt_pkg::FILT_W-1 -: ascnt_pkg::MAG_W];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_time_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_time_reg <= last_time_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg  <= tick_next;
        total_reg <= total_next;
        seen_reg  <= seen_next;
        fmag_reg  <= fmag_next;
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Accelerometer step counter testbench
// Sends three-axis samples over the valid/ready sample channel with random
// gaps and stalls. The expected step total, step flag and filtered magnitude
// are worked out in this file and checked against every result in order.
// Registers are written over the APB port between phases, while no sample
// is in flight.
// ----------------------------------------------------------------------------
module tb_top;
    import ascnt_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 60;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 153;

    typedef struct {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
        logic [TICK_W-1:0]       tick;
    } accel_sample_t;

    typedef struct {
        logic [COUNT_W-1:0] step_total;
        logic               step_seen;
        logic [MAG_W-1:0]   filtered_mag;
    } step_report_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    ascnt_sample_if accel_ch ();
    ascnt_result_if report_ch ();

    // Expected results in acceptance order, and the pedometer state behind them.
    step_report_t        pending_reports[$];
    cfg_t                shadow_cfg;
    logic [FILT_W-1:0]   filt_q420;
    logic [TICK_W-1:0]   last_step_tick;
    logic [COUNT_W-1:0]  step_tally;

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  sample_idle_on  = 1'b1;
    bit  report_stall_on = 1'b1;

    accel_step_counter_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .accel   (accel_ch),
        .report  (report_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a longer one, which can
    // exceed the block's own latency.
    function automatic int pick_idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        return $urandom_range(8, 70);
    endfunction

    function automatic logic [MAG_W-1:0] floor_sqrt(input logic [SUM_W-1:0] value);
        logic [MAG_W-1:0] root;
        logic [MAG_W-1:0] trial;
        root = '0;
        for (int i = MAG_W - 1; i >= 0; i--)
        begin
            trial = root | (MAG_W'(1) << i);
            if (64'(trial) * 64'(trial) <= 64'(value))
                root = trial;
        end
        return root;
    endfunction

    function automatic step_report_t predict_report(input accel_sample_t s);
        longint            ax;
        longint            ay;
        longint            az;
        logic [SUM_W-1:0]  sum_sq;
        logic [MAG_W-1:0]  mag;
        logic [63:0]       acc;
        logic [TICK_W-1:0] since_step;
        step_report_t      rep;
        ax = s.x;
        ay = s.y;
        az = s.z;
        sum_sq = SUM_W'(ax * ax + ay * ay + az * az);
        mag = floor_sqrt(sum_sq);
        acc = 64'(shadow_cfg.filter_gain) * 64'(mag) * 64'd256
            + (64'd65536 - 64'(shadow_cfg.filter_gain)) * 64'(filt_q420);
        filt_q420 = acc[FILT_W+15:16];
        since_step = s.tick - last_step_tick;
        rep.step_seen = 1'b0;
        // The threshold is compared at full Q4.20 precision.
        if (filt_q420 > {shadow_cfg.detect_level, 8'h00}
            && since_step > TICK_W'(shadow_cfg.min_step_interval))
        begin
            step_tally = step_tally + 1'b1;
            last_step_tick = s.tick;
            rep.step_seen = 1'b1;
        end
        rep.step_total = step_tally;
        rep.filtered_mag = filt_q420[FILT_W-1:8];
        return rep;
    endfunction

    function automatic void check_field(input string label, input longint unsigned expected,
                                        input longint unsigned actual);
        if (expected != actual)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, label, expected, actual);
            mismatches++;
        end
    endfunction

    // Drives one request and returns at the edge where it is taken. Valid is
    // left high so that a back-to-back request needs no second assignment.
    task automatic send_sample(input logic signed [ACC_W-1:0] x,
                               input logic signed [ACC_W-1:0] y,
                               input logic signed [ACC_W-1:0] z,
                               input logic [TICK_W-1:0] tick);
        int            gap;
        accel_sample_t s;
        s.x = x;
        s.y = y;
        s.z = z;
        s.tick = tick;
        gap = sample_idle_on ? pick_idle_len() : 0;
        if (gap != 0)
        begin
            accel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        accel_ch.valid    <= 1'b1;
        accel_ch.accel_x  <= s.x;
        accel_ch.accel_y  <= s.y;
        accel_ch.accel_z  <= s.z;
        accel_ch.tick_now <= s.tick;
        do
            @(posedge clk);
        while (accel_ch.ready !== 1'b1);
        pending_reports.push_back(predict_report(s));
    endtask

    task automatic wait_drained();
        accel_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_THRESHOLD: shadow_cfg.detect_level = value;
            REG_INTERVAL:  shadow_cfg.min_step_interval = value;
            REG_GAIN:      shadow_cfg.filter_gain = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] threshold,
                              input logic [CFG_W-1:0] interval,
                              input logic [CFG_W-1:0] gain);
        write_register(REG_THRESHOLD, threshold);
        write_register(REG_INTERVAL, interval);
        write_register(REG_GAIN, gain);
    endtask

    // Reset values: the first step is timed from tick zero and the interval
    // has to be strictly exceeded. Ticks also wrap past 2^32 here.
    task automatic test_reset_defaults();
        send_sample(0, 0, 0, 32'd0);
        send_sample(32767, 32767, 32767, 32'd100);
        send_sample(-32768, -32768, -32768, 32'd200);
        send_sample(-32768, 32767, -1, 32'd201);
        send_sample(1, -1, 1, 32'd401);
        send_sample(0, 0, -32768, 32'd402);
        send_sample(21845, -21846, 4096, 32'hFFFF_FFF0);
        send_sample(4096, 0, 0, 32'hFFFF_FFFF);
        send_sample(-4096, -4096, 0, 32'd150);
        wait_drained();
    endtask

    // Largest gain, zero threshold and zero interval: any nonzero magnitude
    // counts unless the tick repeats.
    task automatic test_full_gain();
        set_config(16'd0, 16'd0, 16'hFFFF);
        send_sample(0, 0, 0, 32'd1000);
        send_sample(1, 0, 0, 32'd1000);
        send_sample(1, 0, 0, 32'd1000);
        send_sample(0, 1, 0, 32'd1001);
        send_sample(32767, 0, 0, 32'd1002);
        send_sample(0, 0, 0, 32'd1003);
        wait_drained();
    endtask

    // Largest threshold and interval with the smallest gain never count.
    task automatic test_never_step();
        set_config(16'hFFFF, 16'hFFFF, 16'd1);
        send_sample(-32768, -32768, -32768, 32'd0);
        send_sample(32767, -32768, 32767, 32'd70000);
        send_sample(0, 0, 0, 32'hFFFF_FFFF);
        send_sample(12345, -12345, -1, 32'h8000_0000);
        wait_drained();
    endtask

    // Mostly walking-like sequences: about 1 g at rest with strides on top,
    // ticks moving forward. The rest are full-range noise and repeated ticks.
    task automatic test_random_walking();
        logic [TICK_W-1:0]       tick_cursor;
        logic [CFG_W-1:0]        threshold;
        logic [CFG_W-1:0]        interval;
        logic [CFG_W-1:0]        gain;
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
        int                      roll;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            sample_idle_on  = (phase % 3) != 2;
            report_stall_on = (phase % 4) != 3;
            roll = $urandom_range(0, 19);
            threshold = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF
                      : CFG_W'($urandom_range(3000, 9000));
            roll = $urandom_range(0, 19);
            interval = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF
                     : CFG_W'($urandom_range(0, 400));
            roll = $urandom_range(0, 9);
            gain = (roll == 0) ? 16'd1 : (roll == 1) ? 16'hFFFF
                 : CFG_W'($urandom_range(1000, 65535));
            set_config(threshold, interval, gain);
            // Every fourth phase starts just below the tick wrap.
            if (phase % 4 == 1)
                tick_cursor = 32'hFFFF_FFFF - TICK_W'($urandom_range(0, 3000));
            else
                tick_cursor = $urandom;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                begin
                    send_sample(ACC_W'($urandom), ACC_W'($urandom), ACC_W'($urandom), $urandom);
                end
                else
                begin
                    if (roll >= 20)
                        tick_cursor = tick_cursor + TICK_W'($urandom_range(1, 80));
                    if ($urandom_range(0, 3) == 0)
                    begin
                        ax = ACC_W'(int'($urandom_range(0, 24000)) - 12000);
                        ay = ACC_W'(int'($urandom_range(0, 24000)) - 12000);
                        az = ACC_W'(4096 + int'($urandom_range(0, 16000)));
                    end
                    else
                    begin
                        ax = ACC_W'(int'($urandom_range(0, 1200)) - 600);
                        ay = ACC_W'(int'($urandom_range(0, 1200)) - 600);
                        az = ACC_W'(3496 + int'($urandom_range(0, 1200)));
                    end
                    send_sample(ax, ay, az, tick_cursor);
                end
            end
        end
    endtask

    // Result side back-pressure.
    always @(posedge clk)
    begin
        if (stall_left == 0 && report_stall_on && $urandom_range(0, 3) == 0)
            stall_left = pick_idle_len();
        if (stall_left != 0)
        begin
            report_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            report_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        step_report_t want;
        if (rst_n === 1'b1 && report_ch.valid === 1'b1 && report_ch.ready === 1'b1)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result with no sample pending, step_total %0d",
                         $time, report_ch.step_total);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("step_total", want.step_total, report_ch.step_total);
                check_field("step_seen", want.step_seen, report_ch.step_seen);
                check_field("filtered_mag", want.filtered_mag, report_ch.filtered_mag);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("accel_step_counter_top verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        accel_ch.valid     = 1'b0;
        accel_ch.accel_x   = '0;
        accel_ch.accel_y   = '0;
        accel_ch.accel_z   = '0;
        accel_ch.tick_now  = '0;
        report_ch.ready    = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        shadow_cfg.detect_level      = THRESHOLD_RST;
        shadow_cfg.min_step_interval = INTERVAL_RST;
        shadow_cfg.filter_gain       = GAIN_RST;
        filt_q420      = '0;
        last_step_tick = '0;
        step_tally     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_full_gain();
        test_never_step();
        test_random_walking();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("accel_step_counter_top verification clean");
        else
            $display("accel_step_counter_top verification failed");
        $finish;
    end

endmodule
